// ===== hdl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, commands, constants and the rotate function.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_FINISH  = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // byte source for the buffer write
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_PAD  = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } byte_src_e;

  typedef struct packed {
    logic      restart;
    logic      count_byte;
    logic      push;
    byte_src_e src;
    logic [2:0] len_idx;
    logic      blk_start;
    logic      round;
    logic      blk_end;
  } dp_cmd_t;

  typedef struct packed {
    logic       full;
    logic [5:0] fill;
  } dp_sts_t;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

  localparam logic [31:0] K [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
    32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
    32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
    32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
    32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
    32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

endpackage

// ===== hdl/sha256_byte_stream_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
// Hashes a message fed one word at a time; emits the digest on finish.
// ----------------------------------------------------------------------------
// Input channel in_valid_i/in_ready_o carries one word: kind and data_byte.
// Kind data appends a byte (dropped after a finish until restart), finish
// pads and emits the digest, restart reloads the initial hash. Kind three
// is ignored. Every 64th byte starts the compression (one round per cycle
// through a single round unit) before the next word is taken. Finish
// pushes the pad byte, zero bytes up to byte 56 of a block (compressing
// any block that fills) and the length bytes, compresses the final block,
// then streams eight digest words, word_index 0 first, last_word on the
// eighth, on out_valid_o/out_ready_i.
// Output is held in a register: a stalled receiver holds the word and
// freezes the emit sequence; input stays blocked until the eighth word is
// loaded into the output register.
// Reset loads the initial hash, clears length and finish state, and drops
// any pending output.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_item_t out_data_o
);
  import sha_pkg::*;

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [31:0] chain_word;
  logic [5:0]  round;
  logic [2:0]  rd_idx;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cmd_o(cmd), .sts_i(sts), .chain_word_i(chain_word),
    .round_o(round), .rd_idx_o(rd_idx)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_byte_i(in_data_i.data_byte),
    .round_i(round), .rd_idx_i(rd_idx), .sts_o(sts), .chain_word_o(chain_word)
  );
endmodule

// ===== hdl/sha_datapath.sv =====
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer, length counter, schedule, working variables and chain words.
// ----------------------------------------------------------------------------
module sha_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::dp_cmd_t  cmd_i,
  input  logic [7:0]        data_byte_i,
  input  logic [5:0]        round_i,
  input  logic [2:0]        rd_idx_i,
  output sha_pkg::dp_sts_t  sts_o,
  output logic [31:0]       chain_word_o
);
  import sha_pkg::*;

  logic [31:0] buf_q [16];
  logic [5:0]  fill_q;
  logic        full_q;
  logic [63:0] msg_bytes_q;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];

  logic [63:0] bits;
  logic [7:0]  wr_byte;
  logic [31:0] w_cur, x15, x2, g0, g1, s0, s1, ch, maj, t1, t2;
  logic [3:0]  ri;

  assign bits = {msg_bytes_q[60:0], 3'b000};
  assign ri   = round_i[3:0];

  always_comb begin
    case (cmd_i.src)
      SRC_DATA: wr_byte = data_byte_i;
      SRC_PAD:  wr_byte = PAD_BYTE;
      SRC_ZERO: wr_byte = 8'h00;
      SRC_LEN:  wr_byte = bits[8*(7-cmd_i.len_idx) +: 8];
      default:  wr_byte = 8'h00;
    endcase
  end

  always_comb begin
    x15 = w_q[4'(ri + 4'd1)];
    x2  = w_q[4'(ri + 4'd14)];
    g0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    g1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    if (round_i < 6'd16) begin
      w_cur = buf_q[ri];
    end else begin
      w_cur = w_q[ri] + g0 + w_q[4'(ri + 4'd9)] + g1;
    end
    s1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + s1 + ch + K[round_i] + w_cur;
    s0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = s0 + maj;
  end

  // pack bytes big-endian into 32-bit buffer words
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b000} +: 8] <= wr_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      full_q      <= 1'b0;
      msg_bytes_q <= '0;
    end else begin
      if (cmd_i.restart) begin
        fill_q      <= '0;
        full_q      <= 1'b0;
        msg_bytes_q <= '0;
      end else begin
        if (cmd_i.count_byte) begin
          msg_bytes_q <= msg_bytes_q + 64'd1;
        end
        if (cmd_i.push) begin
          fill_q <= fill_q + 6'd1;
          full_q <= (fill_q == 6'd63);
        end else if (cmd_i.blk_end) begin
          full_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.blk_start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      w_q[ri] <= w_cur;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
    end else if (cmd_i.restart) begin
      for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
    end else if (cmd_i.blk_end) begin
      for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
    end
  end

  assign sts_o.full   = full_q;
  assign sts_o.fill   = fill_q;
  assign chain_word_o = h_q[rd_idx_i];

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !full_q) else $error("push into full block");
  a_full_at_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |-> fill_q == 6'd0) else $error("full flag without wrap");
  a_no_push_in_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round |-> !cmd_i.push) else $error("push during compression");
endmodule

// ===== hdl/sha_ctrl.sv =====
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sha_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sha_pkg::out_item_t out_data_o,
  output sha_pkg::dp_cmd_t   cmd_o,
  input  sha_pkg::dp_sts_t   sts_i,
  input  logic [31:0]        chain_word_i,
  output logic [5:0]         round_o,
  output logic [2:0]         rd_idx_o
);
  import sha_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_END   = 3'd5;
  localparam logic [2:0] ST_EMIT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       done_q, done_d;
  logic       fin_q, fin_d;
  logic       padded_q, padded_d;
  logic       ovalid_q, ovalid_d;
  out_item_t  odata_q;
  logic       accept, load_out;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE) && !sts_i.full;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign round_o     = cnt_q;
  assign rd_idx_o    = cnt_q[2:0];
  assign load_out    = (state_q == ST_EMIT) && (!ovalid_q || out_ready_i);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    done_d   = done_q;
    fin_d    = fin_q;
    padded_d = padded_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    cmd_o.src = SRC_DATA;
    cmd_o.len_idx = cnt_q[2:0];
    case (state_q)
      ST_IDLE: begin
        if (sts_i.full) begin
          state_d = ST_START;
        end else if (accept) begin
          case (in_data_i.kind)
            KIND_DATA: begin
              if (!done_q) begin
                cmd_o.count_byte = 1'b1;
                cmd_o.push       = 1'b1;
              end
            end
            KIND_FINISH: begin
              cnt_d = '0;
              if (done_q) begin
                state_d = ST_EMIT;
              end else begin
                state_d  = ST_PAD;
                padded_d = 1'b0;
              end
            end
            KIND_RESTART: begin
              cmd_o.restart = 1'b1;
              done_d = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_PAD: begin
        if (sts_i.full) begin
          fin_d   = 1'b1;
          state_d = ST_START;
        end else if (padded_q && sts_i.fill == LEN_POS) begin
          cnt_d   = '0;
          state_d = ST_LEN;
        end else begin
          cmd_o.push = 1'b1;
          cmd_o.src  = padded_q ? SRC_ZERO : SRC_PAD;
          padded_d   = 1'b1;
        end
      end
      ST_LEN: begin
        cmd_o.push = 1'b1;
        cmd_o.src  = SRC_LEN;
        cnt_d      = cnt_q + 6'd1;
        if (cnt_q == 6'd7) begin
          fin_d   = 1'b1;
          done_d  = 1'b1;
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.blk_start = 1'b1;
        cnt_d   = '0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          state_d = ST_END;
        end
      end
      ST_END: begin
        cmd_o.blk_end = 1'b1;
        cnt_d = '0;
        if (fin_q) begin
          fin_d   = 1'b0;
          state_d = done_q ? ST_EMIT : ST_PAD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (load_out) begin
          ovalid_d = 1'b1;
          cnt_d    = cnt_q + 6'd1;
          if (cnt_q[2:0] == 3'd7) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      fin_q    <= 1'b0;
      padded_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      fin_q    <= fin_d;
      padded_q <= padded_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      odata_q.digest_word <= chain_word_i;
      odata_q.word_index  <= cnt_q[2:0];
      odata_q.last_word   <= (cnt_q[2:0] == 3'd7);
    end
  end

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_round_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND && cnt_q == 6'd63 |=> state_q == ST_END)
    else $error("compression length");
  a_emit_leaves_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> done_q) else $error("digest before padding");
endmodule
